// ===== src/qdpr_pkg.sv =====
// Shared types and constants for the quantized dot product / requantize block.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps
`default_nettype none

package qdpr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_ZERO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WGT_ZERO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MULT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHFT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ZERO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_FLR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_PAIRS = 3'd6;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values (conv layer setup)
  localparam logic [7:0]  RST_ACT_ZERO   = 8'd54;
  localparam logic [7:0]  RST_WGT_ZERO   = 8'd115;
  localparam logic [15:0] RST_SCALE_MULT = 16'd50;
  localparam logic [4:0]  RST_SCALE_SHFT = 5'd16;
  localparam logic [7:0]  RST_OUT_ZERO   = 8'd81;
  localparam logic [7:0]  RST_CLAMP_FLR  = 8'd81;

  localparam int unsigned SUM_W   = 32;
  localparam int unsigned PROD_W  = 49;   // 32b signed x 17b signed
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam logic [7:0]  OUT_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] activation;
    logic [7:0] weight;
    logic       last_term;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result;
    logic       clipped_high;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  activation_zero;
    logic [7:0]  weight_zero;
    logic [15:0] scale_multiplier;
    logic [4:0]  scale_shift;
    logic [7:0]  output_zero;
    logic [7:0]  clamp_floor;
    logic        pool_pairs;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic pool_phase;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_REQ
  } back_state_e;

endpackage

`default_nettype wire

// ===== src/quantized_dot_product_requantize.sv =====
// Top level of the uint8 quantized dot product with requantization.
// Depends on qdpr_pkg, qdpr_front, qdpr_fifo and qdpr_back.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i): one term per
//    transaction, an activation byte, a weight byte and last_term. A
//    transaction is taken on a rising edge with valid high and stall low.
//    The front end accumulates one term per cycle; the stall rises only
//    while the four-entry sum queue is full.
//  - Output channel (out_valid_o / out_stall_i / out_data_o): one result
//    per finished dot product, or one per pair when pool_pairs is set.
//    The result sits in an output register and holds while stalled.
//  - Config channel (cfg_valid_i / cfg_ready_o): index and data; ready is
//    always high, indexes past the last register are ignored. Write only
//    while the block is idle.
// A term marked last gives its result once its sum has passed the queue
// read, the multiply and the requantize step into the output register.
// Throughput: 1 term per cycle while the sum queue is not full; the back
// end works on one finished sum at a time, through its idle, multiply and
// requantize states, so bursts of one-term dot products fill the queue
// and then stall the input.
// Reset: the running sum, pairing state and queue clear, registers take
// the conv layer values.
`timescale 1ns / 1ps
`default_nettype none

module quantized_dot_product_requantize (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  qdpr_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output qdpr_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qdpr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [qdpr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import qdpr_pkg::*;

  cfg_t             cfg_d, cfg_q;
  logic             q_push, q_pop, q_full, q_empty;
  logic [SUM_W-1:0] q_wdata, q_head;
  back_status_t     bk_status;

  // Config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ACT_ZERO:   cfg_d.activation_zero  = cfg_data_i[7:0];
        REG_WGT_ZERO:   cfg_d.weight_zero      = cfg_data_i[7:0];
        REG_SCALE_MULT: cfg_d.scale_multiplier = cfg_data_i;
        REG_SCALE_SHFT: cfg_d.scale_shift      = cfg_data_i[4:0];
        REG_OUT_ZERO:   cfg_d.output_zero      = cfg_data_i[7:0];
        REG_CLAMP_FLR:  cfg_d.clamp_floor      = cfg_data_i[7:0];
        REG_POOL_PAIRS: cfg_d.pool_pairs       = cfg_data_i[0];
        default:        cfg_d = cfg_q;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{activation_zero:  RST_ACT_ZERO,
                 weight_zero:      RST_WGT_ZERO,
                 scale_multiplier: RST_SCALE_MULT,
                 scale_shift:      RST_SCALE_SHFT,
                 output_zero:      RST_OUT_ZERO,
                 clamp_floor:      RST_CLAMP_FLR,
                 pool_pairs:       1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: MAC, one term per cycle while the queue is not full
  qdpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  // Finished sums wait here so the MAC keeps running while the back end works
  qdpr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Back: scale, shift, offset, clamp, pairwise max
  qdpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .status_o    (bk_status)
  );

  // Checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("sum pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("sum popped from an empty queue");

  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> bk_status.busy)
    else $error("back end idle after taking a sum");

  a_pool_off_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_q.pool_pairs && out_valid_o && !$past(out_valid_o)) |-> !bk_status.pool_phase)
    else $error("pair phase left set while pooling is off");

endmodule

`default_nettype wire

// ===== src/qdpr_front.sv =====
// Front end: takes terms, removes zero points and accumulates the products.
// Depends on qdpr_pkg; pushes finished sums into qdpr_fifo.
`timescale 1ns / 1ps
`default_nettype none

module qdpr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  qdpr_pkg::in_item_t           in_data_i,
  input  qdpr_pkg::cfg_t               cfg_i,
  input  logic                         q_full_i,
  output logic                         in_stall_o,
  output logic                         push_o,
  output logic [qdpr_pkg::SUM_W-1:0]   push_data_o
);
  import qdpr_pkg::*;

  logic signed [8:0]  act_s;
  logic signed [8:0]  wgt_s;
  logic signed [17:0] term_s;
  logic [SUM_W-1:0]   sum_d, sum_q, sum_next;
  logic               accept;

  assign act_s  = $signed({1'b0, in_data_i.activation}) - $signed({1'b0, cfg_i.activation_zero});
  assign wgt_s  = $signed({1'b0, in_data_i.weight}) - $signed({1'b0, cfg_i.weight_zero});
  assign term_s = act_s * wgt_s;

  // wraps mod 2^32
  assign sum_next = sum_q + {{(SUM_W-18){term_s[17]}}, term_s};

  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i && !q_full_i;
  assign push_o      = accept && in_data_i.last_term;
  assign push_data_o = sum_next;

  always_comb begin
    sum_d = sum_q;
    if (accept) begin
      sum_d = in_data_i.last_term ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/qdpr_fifo.sv =====
// Short queue of finished sums between front and back end.
// Depends on qdpr_pkg for depth and width.
`timescale 1ns / 1ps
`default_nettype none

module qdpr_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [qdpr_pkg::SUM_W-1:0]   push_data_i,
  input  logic                         pop_i,
  output logic [qdpr_pkg::SUM_W-1:0]   head_o,
  output logic                         full_o,
  output logic                         empty_o
);
  import qdpr_pkg::*;

  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  logic [SUM_W-1:0]  mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_d, cnt_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/qdpr_back.sv =====
// Back end: scales, shifts, offsets and clamps sums; pairs results with pool_pairs.
// Depends on qdpr_pkg; pops sums from qdpr_fifo and owns the output register.
`timescale 1ns / 1ps
`default_nettype none

module qdpr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qdpr_pkg::cfg_t               cfg_i,
  input  logic [qdpr_pkg::SUM_W-1:0]   head_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output qdpr_pkg::out_item_t          out_data_o,
  output qdpr_pkg::back_status_t       status_o
);
  import qdpr_pkg::*;

  back_state_e             state_d, state_q;
  logic [SUM_W-1:0]        sum_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] shifted, offset, floored, floor_s;
  logic [8:0]              word, held_d, held_q, pick;
  logic                    phase_d, phase_q;
  logic                    out_valid_d, out_valid_q;
  out_item_t               out_d, out_q;
  logic                    out_free;
  logic                    load_sum, load_prod;

  assign shifted = prod_q >>> cfg_i.scale_shift;
  assign offset  = shifted + $signed({{(PROD_W-8){1'b0}}, cfg_i.output_zero});
  assign floor_s = $signed({{(PROD_W-8){1'b0}}, cfg_i.clamp_floor});
  assign floored = (offset < floor_s) ? floor_s : offset;
  // floor first, then the cap at 255 (a floor value never flags a clip)
  assign word    = (floored > $signed({{(PROD_W-8){1'b0}}, OUT_MAX})) ? 9'h1FF
                                                                      : {1'b0, floored[7:0]};
  // ties keep the earlier result of the pair
  assign pick    = (held_q[7:0] >= word[7:0]) ? held_q : word;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    load_sum    = 1'b0;
    load_prod   = 1'b0;
    held_d      = held_q;
    phase_d     = phase_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          load_sum = 1'b1;
          state_d  = BK_MUL;
        end
      end
      BK_MUL: begin
        load_prod = 1'b1;
        state_d   = BK_REQ;
      end
      BK_REQ: begin
        if (cfg_i.pool_pairs && !phase_q) begin
          held_d  = word;
          phase_d = 1'b1;
          state_d = BK_IDLE;
        end else if (out_free) begin
          out_d       = cfg_i.pool_pairs
                        ? out_item_t'{result: pick[7:0], clipped_high: pick[8]}
                        : out_item_t'{result: word[7:0], clipped_high: word[8]};
          out_valid_d = 1'b1;
          phase_d     = 1'b0;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      held_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_sum) begin
      sum_q <= head_i;
    end
    if (load_prod) begin
      prod_q <= $signed(sum_q) * $signed({1'b0, cfg_i.scale_multiplier});
    end
    out_q <= out_d;
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;
  assign status_o.busy       = (state_q != BK_IDLE);
  assign status_o.pool_phase = phase_q;

endmodule

`default_nettype wire
